// ----- hw/rtl/amcfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package amcfd_pkg;

	// buffer depth default
	localparam int FRAME_BYTES_DEF = 12;

	// framing and field bytes
	localparam logic [7:0] BYTE_OPEN  = 8'h7B;
	localparam logic [7:0] BYTE_CLOSE = 8'h7D;
	localparam logic [7:0] BYTE_QUERY = 8'h3F;
	localparam logic [7:0] BYTE_PLUS  = 8'h2B;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] GEST_1     = 8'h31;
	localparam logic [7:0] GEST_2     = 8'h32;
	localparam logic [7:0] GEST_3     = 8'h33;
	localparam logic [7:0] GEST_4     = 8'h34;

	// buffer positions
	localparam int POS_SEL_A = 1;
	localparam int POS_SEL_B = 2;
	localparam int POS_GEST  = 3;
	localparam int POS_SPEED = 3;
	localparam int POS_ANGLE = 7;

	// direction and way codes
	localparam logic [3:0] DIR_STOP   = 4'd1;
	localparam logic [3:0] DIR_GEST_1 = 4'd10;
	localparam logic [3:0] DIR_GEST_2 = 4'd11;
	localparam logic [3:0] DIR_GEST_3 = 4'd12;
	localparam logic [3:0] DIR_GEST_4 = 4'd13;
	localparam logic [2:0] WAY_NONE   = 3'd0;
	localparam logic [2:0] WAY_FWD    = 3'd5;
	localparam logic [2:0] WAY_TURN   = 3'd6;

	localparam logic       KIND_MOTION  = 1'b0;
	localparam logic       KIND_GESTURE = 1'b1;

	// angle clamp, hundredths
	localparam logic signed [18:0] ANGLE_MAX = 19'sd9000;

	// angle * 157 / 180: first /4 by shift, then /45 by reciprocal
	localparam logic [7:0]  ANGLE_MUL   = 8'd157;
	localparam logic [21:0] RECIP_45    = 22'd2982617;
	localparam int          RECIP_SHIFT = 27;

	// digit value: byte - '0', signed, -48..207
	function automatic logic signed [8:0] digit_val(input logic [7:0] b);
		return $signed({1'b0, b}) - 9'sd48;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ascii_motion_command_frame_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake         | Payload
// --------+-------------------+--------------------------------------------
// in      | in_valid/in_stall | rx_byte
// out     | out_valid/out_stall | frame_kind, direction, way_valid, way,
//         |                   | velocity_centi, angle_scaled
//
// One byte per cycle is accepted while in_stall is low. A closing byte's
// result passes through four registers: input register, frame decode,
// angle multiply, reciprocal divide by 45. The s4 divide multiplier sets
// the clock path.
// Reset (arst_n low) clears the frame buffer, write index, collect flag and
// all stage valids. A stalled output holds s4; the stages behind it keep
// filling their bubbles, and bytes that close no frame still pass s1.

module ascii_motion_command_frame_decoder #(
	parameter int FRAME_BYTES = amcfd_pkg::FRAME_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [7:0]  rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    frame_kind,
	output logic             [3:0]  direction,
	output logic                    way_valid,
	output logic             [2:0]  way,
	output logic signed      [16:0] velocity_centi,
	output logic signed      [16:0] angle_scaled
);
	import amcfd_pkg::*;

	localparam int IDX_W  = $clog2(FRAME_BYTES + 1);
	localparam int ADDR_W = $clog2(FRAME_BYTES);

	// ---------------- stage enables ----------------
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4, adv1;

	logic [7:0] byte_s1;
	logic       open_b, close_b;

	assign open_b  = (byte_s1 == BYTE_OPEN);
	assign close_b = (byte_s1 == BYTE_CLOSE);

	assign en4  = !v4_s4 || !out_stall;
	assign en3  = !v3_s3 || en4;
	assign en2  = !v2_s2 || en3;
	// bytes that close no frame leave s1 without needing room in s2
	assign adv1 = !close_b || en2;
	assign en1  = !v1_s1 || adv1;

	assign in_stall = !en1;

	// ---------------- s1: input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			byte_s1 <= rx_byte;
		end
	end

	// ---------------- frame state ----------------
	logic [7:0]       buf_q [FRAME_BYTES];
	logic [IDX_W-1:0] wr_idx_q;
	logic             collecting_q;
	logic             coll_next, step, store, clear;

	assign coll_next = close_b ? 1'b0 : (open_b ? 1'b1 : collecting_q);
	assign step      = v1_s1 && adv1;
	assign store     = step && coll_next && (wr_idx_q < IDX_W'(FRAME_BYTES));
	assign clear     = step && close_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				buf_q[i] <= 8'd0;
			end
			wr_idx_q     <= '0;
			collecting_q <= 1'b0;
		end else if (clear) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				buf_q[i] <= 8'd0;
			end
			wr_idx_q     <= '0;
			collecting_q <= 1'b0;
		end else if (step) begin
			collecting_q <= coll_next;
			if (store) begin
				for (int i = 0; i < FRAME_BYTES; i++) begin
					if (wr_idx_q[ADDR_W-1:0] == ADDR_W'(i)) begin
						buf_q[i] <= byte_s1;
					end
				end
				wr_idx_q <= wr_idx_q + IDX_W'(1);
			end
		end
	end

	// ---------------- frame decode (s1 -> s2) ----------------
	logic                gesture;
	logic         [7:0]  sel_a, sel_b;
	logic         [3:0]  dir_c;
	logic                wv_c;
	logic         [2:0]  way_c;
	logic signed  [18:0] speed_c, angle_c;
	logic signed  [16:0] angle_cl;

	assign gesture = (buf_q[POS_SEL_A] == BYTE_QUERY) && (buf_q[POS_SEL_B] == BYTE_PLUS);
	assign sel_a   = buf_q[POS_SEL_A] - BYTE_ZERO;
	assign sel_b   = buf_q[POS_SEL_B] - BYTE_ZERO;

	assign speed_c = 19'(digit_val(buf_q[POS_SPEED]))     * 19'sd1000
	               + 19'(digit_val(buf_q[POS_SPEED + 1])) * 19'sd100
	               + 19'(digit_val(buf_q[POS_SPEED + 2])) * 19'sd10
	               + 19'(digit_val(buf_q[POS_SPEED + 3]));
	assign angle_c = 19'(digit_val(buf_q[POS_ANGLE]))     * 19'sd1000
	               + 19'(digit_val(buf_q[POS_ANGLE + 1])) * 19'sd100
	               + 19'(digit_val(buf_q[POS_ANGLE + 2])) * 19'sd10
	               + 19'(digit_val(buf_q[POS_ANGLE + 3]));
	// clamp high side only; negative angles pass
	assign angle_cl = (angle_c >= ANGLE_MAX) ? 17'(ANGLE_MAX) : angle_c[16:0];

	always_comb begin
		dir_c = DIR_STOP;
		wv_c  = 1'b0;
		way_c = WAY_NONE;
		if (gesture) begin
			case (buf_q[POS_GEST])
				GEST_1: begin
					dir_c = DIR_GEST_1;
					wv_c  = 1'b1;
					way_c = WAY_FWD;
				end
				GEST_2: begin
					dir_c = DIR_GEST_2;
					wv_c  = 1'b1;
					way_c = WAY_TURN;
				end
				GEST_3: begin
					dir_c = DIR_GEST_3;
					wv_c  = 1'b1;
					way_c = WAY_TURN;
				end
				GEST_4: begin
					dir_c = DIR_GEST_4;
					wv_c  = 1'b1;
					way_c = WAY_TURN;
				end
				default: begin
					dir_c = DIR_STOP;
				end
			endcase
		end else if (sel_a < 8'd3 && sel_b < 8'd3) begin
			// 3x3 table: 1 + 3*row + col
			dir_c = 4'd1 + 4'(sel_a[1:0]) * 4'd3 + 4'(sel_b[1:0]);
		end
	end

	logic                kind_s2, wv_s2;
	logic         [3:0]  dir_s2;
	logic         [2:0]  way_s2;
	logic signed  [18:0] speed_s2;
	logic signed  [16:0] angle_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1 && close_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2  <= gesture ? KIND_GESTURE : KIND_MOTION;
			dir_s2   <= dir_c;
			wv_s2    <= wv_c;
			way_s2   <= way_c;
			speed_s2 <= gesture ? 19'sd0 : speed_c;
			angle_s2 <= gesture ? 17'sd0 : angle_cl;
		end
	end

	// ---------------- s3: velocity, angle * 157 ----------------
	logic signed  [18:0] speed_rnd;
	logic         [16:0] angle_neg;
	logic         [15:0] angle_abs;

	// truncate toward zero
	assign speed_rnd = speed_s2 + (speed_s2[18] ? 19'sd3 : 19'sd0);
	assign angle_neg = -angle_s2;
	assign angle_abs = angle_s2[16] ? angle_neg[15:0] : angle_s2[15:0];

	logic                kind_s3, wv_s3, neg_s3;
	logic         [3:0]  dir_s3;
	logic         [2:0]  way_s3;
	logic signed  [16:0] vel_s3;
	logic         [23:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			kind_s3 <= kind_s2;
			dir_s3  <= dir_s2;
			wv_s3   <= wv_s2;
			way_s3  <= way_s2;
			vel_s3  <= speed_rnd[18:2];
			neg_s3  <= angle_s2[16];
			prod_s3 <= 24'(angle_abs) * 24'(ANGLE_MUL);
		end
	end

	// ---------------- s4: / 180 as >>2 then reciprocal of 45 ----------------
	logic [43:0] recip_prod;
	logic [16:0] quot, quot_neg;

	assign recip_prod = 44'(prod_s3[23:2]) * 44'(RECIP_45);
	assign quot       = recip_prod[RECIP_SHIFT +: 17];
	assign quot_neg   = -quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_s4 <= 1'b0;
		end else if (en4) begin
			v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			frame_kind     <= kind_s3;
			direction      <= dir_s3;
			way_valid      <= wv_s3;
			way            <= way_s3;
			velocity_centi <= vel_s3;
			angle_scaled   <= neg_s3 ? $signed(quot_neg) : $signed(quot);
		end
	end

	assign out_valid = v4_s4;

endmodule

`default_nettype wire

// ----- dv/frame_cmd_monitor.sv -----
`timescale 1ns / 1ps

module frame_cmd_monitor
	import amcfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic        [7:0]  rx_byte,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic               frame_kind,
	input  wire logic        [3:0]  direction,
	input  wire logic               way_valid,
	input  wire logic        [2:0]  way,
	input  wire logic signed [16:0] velocity_centi,
	input  wire logic signed [16:0] angle_scaled,
	output int                      errors,
	output int                      outstanding,
	output int                      frames_checked,
	output int                      gestures_checked
);

	localparam int DIGIT_BASE = 48;
	localparam int DIR_COLS   = 3;
	localparam int SPEED_DIV  = 4;
	localparam int ANGLE_NUM  = 157;
	localparam int ANGLE_DEN  = 180;

	typedef struct packed {
		logic               kind;
		logic        [3:0]  dir;
		logic               way_ok;
		logic        [2:0]  way_code;
		logic signed [16:0] vel;
		logic signed [16:0] ang;
	} motion_cmd_t;

	logic [7:0]  frm_buf [FRAME_BYTES_DEF];
	int          wr_idx;
	logic        collect_on;
	motion_cmd_t decoded_cmds [$];

	function automatic int digit_at(input int pos);
		return int'(frm_buf[pos]) - DIGIT_BASE;
	endfunction

	function automatic int four_digit_value(input int first);
		return digit_at(first) * 1000 + digit_at(first + 1) * 100 +
			digit_at(first + 2) * 10 + digit_at(first + 3);
	endfunction

	task automatic clear_frame();
		foreach (frm_buf[i])
			frm_buf[i] = 8'h00;
		wr_idx = 0;
		collect_on = 1'b0;
	endtask

	function automatic motion_cmd_t decode_frame();
		motion_cmd_t c;
		logic [7:0]  sel_a;
		logic [7:0]  sel_b;
		int          speed;
		int          angle;
		c = '0;
		c.dir = DIR_STOP;
		c.way_code = WAY_NONE;
		if (frm_buf[POS_SEL_A] == BYTE_QUERY && frm_buf[POS_SEL_B] == BYTE_PLUS) begin
			c.kind = KIND_GESTURE;
			c.way_ok = 1'b1;
			case (frm_buf[POS_GEST])
				GEST_1: begin
					c.dir = DIR_GEST_1;
					c.way_code = WAY_FWD;
				end
				GEST_2: begin
					c.dir = DIR_GEST_2;
					c.way_code = WAY_TURN;
				end
				GEST_3: begin
					c.dir = DIR_GEST_3;
					c.way_code = WAY_TURN;
				end
				GEST_4: begin
					c.dir = DIR_GEST_4;
					c.way_code = WAY_TURN;
				end
				default: c.way_ok = 1'b0;
			endcase
		end else begin
			c.kind = KIND_MOTION;
			// selectors wrap as bytes, so anything below '0' is out of range too
			sel_a = frm_buf[POS_SEL_A] - BYTE_ZERO;
			sel_b = frm_buf[POS_SEL_B] - BYTE_ZERO;
			if (sel_a < DIR_COLS && sel_b < DIR_COLS)
				c.dir = 4'(int'(DIR_STOP) + DIR_COLS * int'(sel_a) + int'(sel_b));
			speed = four_digit_value(POS_SPEED);
			angle = four_digit_value(POS_ANGLE);
			if (angle >= ANGLE_MAX)
				angle = ANGLE_MAX;
			// int division truncates toward zero, as the block must
			c.vel = 17'(speed / SPEED_DIV);
			c.ang = 17'(angle * ANGLE_NUM / ANGLE_DEN);
		end
		return c;
	endfunction

	task automatic absorb_byte(input logic [7:0] b);
		if (b == BYTE_OPEN)
			collect_on = 1'b1;
		if (b == BYTE_CLOSE)
			collect_on = 1'b0;
		if (collect_on) begin
			if (wr_idx < FRAME_BYTES_DEF) begin
				frm_buf[wr_idx] = b;
				wr_idx++;
			end
		end else if (b == BYTE_CLOSE) begin
			decoded_cmds.push_back(decode_frame());
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$display("%t %s mismatch: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		motion_cmd_t want;
		if (!arst_n) begin
			clear_frame();
			decoded_cmds.delete();
		end else begin
			// a result can never stem from a byte taken at the same edge
			if (out_valid && !out_stall) begin
				if (decoded_cmds.size() == 0) begin
					$display("%t unexpected item: kind %0d dir %0d way %0d/%0d vel %0d ang %0d",
						$time, frame_kind, direction, way_valid, way,
						velocity_centi, angle_scaled);
					errors++;
				end else begin
					want = decoded_cmds.pop_front();
					check_field("frame_kind", want.kind, frame_kind);
					check_field("direction", want.dir, direction);
					check_field("way_valid", want.way_ok, way_valid);
					check_field("way", want.way_code, way);
					check_field("velocity_centi", want.vel, velocity_centi);
					check_field("angle_scaled", want.ang, angle_scaled);
					frames_checked++;
					if (want.kind == KIND_GESTURE)
						gestures_checked++;
				end
			end
			if (in_valid && !in_stall)
				absorb_byte(rx_byte);
		end
		outstanding = decoded_cmds.size();
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import amcfd_pkg::*;

	localparam int RANDOM_BYTES = 1600;  // framed bytes in the random part
	localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
	localparam int DRAIN_CYCLES = 12;    // pipeline is four deep
	localparam int MAX_GAP      = 12;
	localparam int MAX_BURST    = 48;
	localparam int LONG_BURST   = 400;   // stretch with no sender idling

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic        [7:0]  rx_byte   = 8'h00;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic               frame_kind;
	logic        [3:0]  direction;
	logic               way_valid;
	logic        [2:0]  way;
	logic signed [16:0] velocity_centi;
	logic signed [16:0] angle_scaled;

	int errors;
	int outstanding;
	int frames_checked;
	int gestures_checked;
	int bytes_sent  = 0;
	int burst_left  = 0;
	int idle_cycles = 0;

	ascii_motion_command_frame_decoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_kind     (frame_kind),
		.direction      (direction),
		.way_valid      (way_valid),
		.way            (way),
		.velocity_centi (velocity_centi),
		.angle_scaled   (angle_scaled)
	);

	// predicts every decoded command and compares it on the output channel
	frame_cmd_monitor i_mon (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.frame_kind       (frame_kind),
		.direction        (direction),
		.way_valid        (way_valid),
		.way              (way),
		.velocity_centi   (velocity_centi),
		.angle_scaled     (angle_scaled),
		.errors           (errors),
		.outstanding      (outstanding),
		.frames_checked   (frames_checked),
		.gestures_checked (gestures_checked)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// any byte but one; used to keep stray opens or closes out
	function automatic logic [7:0] byte_except(input logic [7:0] banned);
		logic [7:0] b;
		b = 8'($urandom);
		while (b == banned)
			b = 8'($urandom);
		return b;
	endfunction

	// mostly a decimal digit, sometimes any byte that does not close the frame
	function automatic logic [7:0] field_byte();
		if ($urandom_range(0, 99) < 85)
			return BYTE_ZERO + 8'($urandom_range(0, 9));
		return byte_except(BYTE_CLOSE);
	endfunction

	// Sender side. Bytes go out in bursts; between bursts valid drops for a
	// random gap. Stall is sampled at the falling edge, where it has settled,
	// so the transfer decision never races the rising edge.
	task automatic send_byte(input logic [7:0] b);
		logic stalled;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? LONG_BURST :
				$urandom_range(1, MAX_BURST);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		bytes_sent++;
		burst_left--;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Receiver side: stall behavior switches between free running, light and
	// heavy random back-pressure, and a fixed duty pattern.
	initial begin
		stall_mode_e mode;
		int          mode_left;
		mode = STALL_NONE;
		mode_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = stall_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			case (mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
				default:     out_stall <= ((mode_left % 16) < 5);
			endcase
		end
	end

	// watchdog: nothing moving on either channel for too long ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%t watchdog: no transfer for %0d cycles, %0d commands pending",
					$time, IDLE_LIMIT, outstanding);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		int noise_len;
		int noise_bytes;
		int random_start;
		noise_bytes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// stray close with no open: decodes the all-zero buffer
		send_byte(BYTE_CLOSE);
		// gesture, last gesture code
		send_text("{?+4}");
		// largest selectors and speed, angle well above its clamp
		send_text("{2299999999}");
		// a second open is stored, not a restart
		send_text("{{}");
		// byte extremes in the two selector positions
		send_byte(BYTE_OPEN);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(BYTE_CLOSE);

		// --- random part ---
		// Mostly well formed frames with random content; the rest are
		// overruns past the buffer, stubs and near-miss gesture headers, and
		// line noise between frames. Noise bytes other than stray closes do not count.
		random_start = bytes_sent;
		while (bytes_sent - random_start - noise_bytes < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// motion frame: two selectors, four speed and four angle digits
				send_byte(BYTE_OPEN);
				repeat (2)
					send_byte(($urandom_range(0, 4) != 0) ?
						BYTE_ZERO + 8'($urandom_range(0, 2)) : field_byte());
				repeat (8)
					send_byte(field_byte());
				send_byte(BYTE_CLOSE);
			end else if (pick < 75) begin
				// gesture frame, sometimes with trailing bytes or a bad code
				send_byte(BYTE_OPEN);
				send_byte(BYTE_QUERY);
				send_byte(BYTE_PLUS);
				send_byte(($urandom_range(0, 4) != 0) ?
					BYTE_ZERO + 8'($urandom_range(0, 4)) : byte_except(BYTE_CLOSE));
				repeat ($urandom_range(0, 3))
					send_byte(field_byte());
				send_byte(BYTE_CLOSE);
			end else if (pick < 85) begin
				// overrun: usually fills the buffer and keeps going
				send_byte(BYTE_OPEN);
				repeat ($urandom_range(10, 20))
					send_byte(field_byte());
				send_byte(BYTE_CLOSE);
			end else if (pick < 93) begin
				// short frame built from header-like bytes
				send_byte(BYTE_OPEN);
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 3))
						0:       send_byte(BYTE_QUERY);
						1:       send_byte(BYTE_PLUS);
						default: send_byte(field_byte());
					endcase
				end
				send_byte(BYTE_CLOSE);
			end else begin
				// noise outside a frame, now and then a stray close
				noise_len = $urandom_range(1, 6);
				noise_bytes += noise_len;
				repeat (noise_len)
					send_byte(byte_except(BYTE_OPEN));
				if ($urandom_range(0, 2) == 0)
					send_byte(BYTE_CLOSE);
			end
		end
		in_valid <= 1'b0;

		// drain: every predicted command back, then quiet cycles before the report
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d bytes in, %0d commands checked (%0d gesture, %0d motion)",
			bytes_sent, frames_checked, gestures_checked, frames_checked - gestures_checked);
		$display("with random sender gaps and receiver back-pressure; %0d mismatches",
			errors);
		if (errors == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/amcfd_pkg.sv
hw/rtl/ascii_motion_command_frame_decoder.sv
dv/frame_cmd_monitor.sv
dv/tb.sv
